@@ hdl/bpe_pkg.sv @@
// Package for the Bezier point evaluator.
// Holds shared widths, the register index codes, the pipeline control type
// and the rounded interpolation function. Depends on nothing.
package bpe_pkg;

    localparam int COORD_W     = 16;
    localparam int PARAM_W     = 17;
    localparam int COUNT_W     = 3;
    localparam int CFG_W       = 32;
    localparam int NUM_REGS_PT = 4;
    localparam int MAX_POINTS  = 4;

    localparam logic [PARAM_W-1:0] T_ONE       = 17'h10000;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd2;
    localparam logic [COUNT_W-1:0] COUNT_MIN   = 3'd2;

    typedef enum logic [2:0] {
        REG_COUNT  = 3'd0,
        REG_POINT0 = 3'd1,
        REG_POINT1 = 3'd2,
        REG_POINT2 = 3'd3,
        REG_POINT3 = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [PARAM_W-1:0] t;
        logic [COUNT_W-1:0] n;
    } t_ctl;

    // Computes a + t*(b - a) in Q12.4 with t in Q1.16, rounding half up.
    function automatic logic signed [COORD_W-1:0] interp(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic [PARAM_W-1:0]        t
    );
        logic signed [16:0] diff;
        logic signed [17:0] t_s;
        logic signed [34:0] prod;
        logic signed [35:0] acc;
        diff = $signed({b[15], b}) - $signed({a[15], a});
        t_s  = $signed({1'b0, t});
        prod = 35'(diff * t_s);
        acc  = $signed({{4{a[15]}}, a, 16'h0000}) + $signed({prod[34], prod})
               + 36'sd32768;
        return acc[31:16];
    endfunction

endpackage

@@ hdl/bpe_round.sv @@
// One de Casteljau reduction round as a registered pipeline stage.
// Depends on bpe_pkg for the control type and the interpolation function.
module bpe_round #(
    parameter int MAX_POINTS = bpe_pkg::MAX_POINTS,
    parameter int ROUND      = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  bpe_pkg::t_ctl                       i_ctl,
    input  logic signed [bpe_pkg::COORD_W-1:0]  i_px [MAX_POINTS],
    input  logic signed [bpe_pkg::COORD_W-1:0]  i_py [MAX_POINTS],
    output logic                                o_valid,
    input  logic                                i_ready,
    output bpe_pkg::t_ctl                       o_ctl,
    output logic signed [bpe_pkg::COORD_W-1:0]  o_px [MAX_POINTS],
    output logic signed [bpe_pkg::COORD_W-1:0]  o_py [MAX_POINTS]
);

    logic                                r_valid;
    bpe_pkg::t_ctl                       r_ctl;
    logic signed [bpe_pkg::COORD_W-1:0]  r_px [MAX_POINTS];
    logic signed [bpe_pkg::COORD_W-1:0]  r_py [MAX_POINTS];
    logic signed [bpe_pkg::COORD_W-1:0]  n_px [MAX_POINTS];
    logic signed [bpe_pkg::COORD_W-1:0]  n_py [MAX_POINTS];
    logic                                w_active;
    logic                                w_load;

    assign o_ready  = !r_valid || i_ready;
    assign w_load   = i_valid && o_ready;
    // The round runs only while more than one point is left.
    assign w_active = bpe_pkg::COUNT_W'(ROUND) < i_ctl.n;

    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_lane
        if (i < MAX_POINTS - ROUND) begin : g_calc
            assign n_px[i] = w_active ? bpe_pkg::interp(i_px[i], i_px[i+1], i_ctl.t)
                                      : i_px[i];
            assign n_py[i] = w_active ? bpe_pkg::interp(i_py[i], i_py[i+1], i_ctl.t)
                                      : i_py[i];
        end else begin : g_pass
            assign n_px[i] = i_px[i];
            assign n_py[i] = i_py[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ctl <= i_ctl;
            r_px  <= n_px;
            r_py  <= n_py;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_px    = r_px;
    assign o_py    = r_py;

endmodule

@@ hdl/bezier_point_evaluator.sv @@
// Top level of the Bezier point evaluator: configuration registers, input
// stage and the chain of reduction rounds. Depends on bpe_pkg and bpe_round.
//
// Usage: control points and the point count are written through the plain
// write port (i_cfg_wr_en, i_cfg_index, i_cfg_data) while no transfer is in
// flight. Index 0 is the point count, indexes 1 to 4 the control points with
// x in bits 15:0 and y in bits 31:16. Writes to other indexes are dropped.
// Each transfer on the input channel carries one curve parameter t in Q1.16;
// values above 1.0 are taken as 1.0. Each one yields exactly one transfer on
// the output channel with the curve point in Q12.4.
// The pipeline is one input register and one register stage per reduction
// round, each round stage holding a single multiply and add per coordinate.
// One transfer is taken every cycle unless a receiver stall fills all stages.
// When the receiver stalls, every full stage holds its item and ready ripples
// back; input ready drops only when all stages are full.
// Reset clears all stage valid bits, sets the count to two and clears the
// control points.
module bezier_point_evaluator #(
    parameter int MAX_POINTS = bpe_pkg::MAX_POINTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [2:0]                          i_cfg_index,
    input  logic [bpe_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [bpe_pkg::PARAM_W-1:0]         i_curve_param,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [bpe_pkg::COORD_W-1:0]  o_point_x,
    output logic signed [bpe_pkg::COORD_W-1:0]  o_point_y
);

    localparam logic [bpe_pkg::COUNT_W-1:0] CountMax = bpe_pkg::COUNT_W'(MAX_POINTS);

    logic [bpe_pkg::COUNT_W-1:0]         r_count;
    logic [bpe_pkg::CFG_W-1:0]           r_point [bpe_pkg::NUM_REGS_PT];

    logic                                r_valid0;
    bpe_pkg::t_ctl                       r_ctl0;
    logic signed [bpe_pkg::COORD_W-1:0]  r_px0 [MAX_POINTS];
    logic signed [bpe_pkg::COORD_W-1:0]  r_py0 [MAX_POINTS];
    bpe_pkg::t_ctl                       n_ctl0;

    logic                                w_valid [MAX_POINTS];
    logic                                w_ready [MAX_POINTS];
    bpe_pkg::t_ctl                       w_ctl   [MAX_POINTS];
    logic signed [bpe_pkg::COORD_W-1:0]  w_px    [MAX_POINTS][MAX_POINTS];
    logic signed [bpe_pkg::COORD_W-1:0]  w_py    [MAX_POINTS][MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= bpe_pkg::COUNT_RESET;
            for (int k = 0; k < bpe_pkg::NUM_REGS_PT; k++) begin
                r_point[k] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            case (bpe_pkg::t_reg_idx'(i_cfg_index))
                bpe_pkg::REG_COUNT: begin
                    r_count <= i_cfg_data[bpe_pkg::COUNT_W-1:0];
                end
                bpe_pkg::REG_POINT0: begin
                    r_point[0] <= i_cfg_data;
                end
                bpe_pkg::REG_POINT1: begin
                    r_point[1] <= i_cfg_data;
                end
                bpe_pkg::REG_POINT2: begin
                    r_point[2] <= i_cfg_data;
                end
                bpe_pkg::REG_POINT3: begin
                    r_point[3] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_ctl0.t = (i_curve_param > bpe_pkg::T_ONE) ? bpe_pkg::T_ONE : i_curve_param;
        if (r_count < bpe_pkg::COUNT_MIN) begin
            n_ctl0.n = bpe_pkg::COUNT_MIN;
        end else if (r_count > CountMax) begin
            n_ctl0.n = CountMax;
        end else begin
            n_ctl0.n = r_count;
        end
    end

    assign o_in_ready = !r_valid0 || w_ready[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (o_in_ready) begin
            r_valid0 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_ctl0 <= n_ctl0;
            for (int j = 0; j < MAX_POINTS; j++) begin
                r_px0[j] <= r_point[j][15:0];
                r_py0[j] <= r_point[j][31:16];
            end
        end
    end

    assign w_valid[0] = r_valid0;
    assign w_ready[0] = o_in_ready;
    assign w_ctl[0]   = r_ctl0;
    for (genvar j = 0; j < MAX_POINTS; j++) begin : g_stage0
        assign w_px[0][j] = r_px0[j];
        assign w_py[0][j] = r_py0[j];
    end

    for (genvar k = 1; k < MAX_POINTS; k++) begin : g_round
        logic next_ready;
        if (k == MAX_POINTS - 1) begin : g_last
            assign next_ready = i_out_ready;
        end else begin : g_mid
            assign next_ready = w_ready[k+1];
        end
        bpe_round #(
            .MAX_POINTS (MAX_POINTS),
            .ROUND      (k)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k-1]),
            .o_ready (w_ready[k]),
            .i_ctl   (w_ctl[k-1]),
            .i_px    (w_px[k-1]),
            .i_py    (w_py[k-1]),
            .o_valid (w_valid[k]),
            .i_ready (next_ready),
            .o_ctl   (w_ctl[k]),
            .o_px    (w_px[k]),
            .o_py    (w_py[k])
        );
    end

    assign o_out_valid = w_valid[MAX_POINTS-1];
    assign o_point_x   = w_px[MAX_POINTS-1][0];
    assign o_point_y   = w_py[MAX_POINTS-1][0];

    a_t_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_curve_param > bpe_pkg::T_ONE))
        |=> (r_ctl0.t == bpe_pkg::T_ONE))
        else $error("Curve parameter above one did not saturate.");

    a_count_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid0 |-> ((r_ctl0.n >= bpe_pkg::COUNT_MIN) && (r_ctl0.n <= CountMax)))
        else $error("Point count in the pipeline is out of range.");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("Input stalled without a stalled output.");

endmodule
